FILE: rtl/mpfgd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the page-mode monochrome framebuffer.
// Used by mpfgd_ctrl, mpfgd_datapath and mono_page_framebuffer_glyph_draw_top.
package mpfgd_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    // operation codes
    localparam logic [2:0] FUNC_FILL   = 3'd0;
    localparam logic [2:0] FUNC_PIXEL  = 3'd1;
    localparam logic [2:0] FUNC_GLYPH  = 3'd2;
    localparam logic [2:0] FUNC_CURSOR = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_CLIP   = 2'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_W     = 2;
    localparam int         CFG_DATA_W      = 6;
    localparam logic [1:0] CFG_INVERTED    = 2'd0;
    localparam logic [1:0] CFG_FONT_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_FONT_HEIGHT = 2'd2;

    localparam logic [4:0] RST_FONT_WIDTH  = 5'd7;
    localparam logic [5:0] RST_FONT_HEIGHT = 6'd10;

    // kind of work the decoded item needs
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_DRAW = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    localparam logic [15:0] SINGLE_PIXEL   = 16'h8000;
    localparam logic [7:0]  BYTE_ONES      = 8'hFF;
    localparam logic [7:0]  BYTE_ZEROS     = 8'h00;
    localparam logic [5:0]  MAX_GLYPH_ROWS = 6'd32;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic        color;
        logic [15:0] glyph_bits;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
        logic       char_done;
    } result_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic draw_step;
        logic sweep;
        logic read_latch;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       draw_empty;
        logic       draw_last;
        logic       sweep_last;
    } dp_status_t;

endpackage

FILE: rtl/mpfgd_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the framebuffer: clearing pass, decode,
// fill sweep, column read-modify-write loop, read wait and result hand-off.
// Depends on mpfgd_pkg.
module mpfgd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    output logic                   result_valid,
    input  logic                   result_stall,
    input  mpfgd_pkg::dp_status_t  status,
    output mpfgd_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_DRAW   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_RDWAIT = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        cmd.accept     = (state_reg == S_IDLE) && item_valid;
        cmd.decode     = (state_reg == S_DECODE);
        cmd.draw_step  = (state_reg == S_DRAW);
        cmd.sweep      = (state_reg == S_CLEAR) || (state_reg == S_FILL);
        cmd.read_latch = (state_reg == S_RDWAIT);
        cmd.out_load   = (state_reg == S_FINISH) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                unique case (status.kind)
                    mpfgd_pkg::KIND_FILL: state_next = S_FILL;
                    mpfgd_pkg::KIND_DRAW: state_next = status.draw_empty ? S_FINISH : S_DRAW;
                    mpfgd_pkg::KIND_READ: state_next = S_RDWAIT;
                    default:              state_next = S_FINISH;
                endcase
            end
            S_FILL:
            begin
                if (status.sweep_last)
                    state_next = S_FINISH;
            end
            S_DRAW:
            begin
                if (status.draw_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:  state_next = S_FINISH;
            S_RDWAIT: state_next = S_FINISH;
            S_FINISH:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

FILE: rtl/mpfgd_datapath.sv
`timescale 1ns / 1ps
// Framebuffer datapath: page store, config registers, text cursor, item decode,
// column read-modify-write pipeline, sweep counter and result registers.
// Depends on mpfgd_pkg; driven by mpfgd_ctrl.
module mpfgd_datapath #(
    parameter int SCREEN_WIDTH  = mpfgd_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = mpfgd_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mpfgd_pkg::item_t                     item,
    input  logic                                 cfg_write,
    input  logic [mpfgd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mpfgd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  mpfgd_pkg::dp_cmd_t                   cmd,
    output mpfgd_pkg::dp_status_t                status,
    output mpfgd_pkg::result_t                   result
);

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH      = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(DEPTH);

    localparam logic [9:0]        WIDTH_L   = 10'(SCREEN_WIDTH);
    localparam logic [9:0]        HEIGHT_L  = 10'(SCREEN_HEIGHT);
    localparam logic [9:0]        PAGES_L   = 10'(PAGE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // architectural state
    mpfgd_pkg::item_t item_reg;
    logic             inverted_reg;
    logic [4:0]       font_w_reg;
    logic [5:0]       font_h_reg;
    logic [7:0]       cursor_x_reg;
    logic [7:0]       cursor_y_reg;
    logic [4:0]       row_idx_reg;
    logic [7:0]       frame_store_reg [DEPTH];

    // decode
    logic [9:0]        sum_x;
    logic [9:0]        sum_y;
    logic [5:0]        eff_h;
    logic [8:0]        glyph_y;
    logic              pix_ok;
    logic              read_ok;
    logic              reject;
    logic              last_row;
    logic              draw_row;
    logic [1:0]        kind_c;
    logic [4:0]        ncol_c;
    logic [7:0]        x0_c;
    logic [8:0]        y_c;
    logic [15:0]       pattern_c;
    mpfgd_pkg::result_t res_c;
    logic [ADDR_W-1:0] row_base_c;
    logic [ADDR_W-1:0] read_addr_c;

    // per-item draw context
    logic [4:0]        ncol_reg;
    logic [4:0]        col_reg;
    logic [7:0]        x0_reg;
    logic [15:0]       pattern_reg;
    logic              color_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [7:0]        mask_reg;
    logic [7:0]        fill_byte_reg;

    // column pipeline
    logic [9:0]        col_x;
    logic              col_ok;
    logic              col_bit;
    logic              col_white;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              wr_white_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;

    // store ports
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    mpfgd_pkg::result_t res_reg;
    mpfgd_pkg::result_t out_reg;

    assign sum_x    = {2'b00, cursor_x_reg} + {5'd0, font_w_reg};
    assign sum_y    = {2'b00, cursor_y_reg} + {4'd0, font_h_reg};
    assign eff_h    = (font_h_reg > mpfgd_pkg::MAX_GLYPH_ROWS) ? mpfgd_pkg::MAX_GLYPH_ROWS
                                                                : font_h_reg;
    assign glyph_y  = {1'b0, cursor_y_reg} + {4'd0, row_idx_reg};
    assign pix_ok   = ({2'b00, item_reg.pixel_x} < WIDTH_L)
                   && ({2'b00, item_reg.pixel_y} < HEIGHT_L);
    assign read_ok  = ({2'b00, item_reg.pixel_x} < WIDTH_L)
                   && ({5'd0, item_reg.pixel_y[7:3]} < PAGES_L);
    // space check only ahead of a character's first row
    assign reject   = (row_idx_reg == 5'd0)
                   && ((sum_x >= WIDTH_L) || (sum_y >= HEIGHT_L));
    assign last_row = ({1'b0, row_idx_reg} + 6'd1) >= eff_h;
    assign draw_row = (eff_h != 6'd0) && ({1'b0, glyph_y} < HEIGHT_L);

    always_comb
    begin
        kind_c          = mpfgd_pkg::KIND_NONE;
        ncol_c          = 5'd0;
        x0_c            = item_reg.pixel_x;
        y_c             = {1'b0, item_reg.pixel_y};
        pattern_c       = mpfgd_pkg::SINGLE_PIXEL;
        res_c.status    = mpfgd_pkg::STAT_DONE;
        res_c.read_data = mpfgd_pkg::BYTE_ZEROS;
        res_c.char_done = 1'b0;
        unique case (item_reg.func)
            mpfgd_pkg::FUNC_FILL:
            begin
                kind_c = mpfgd_pkg::KIND_FILL;
            end
            mpfgd_pkg::FUNC_PIXEL:
            begin
                // a pixel is a one-column row with only its leftmost bit set
                kind_c       = mpfgd_pkg::KIND_DRAW;
                ncol_c       = pix_ok ? 5'd1 : 5'd0;
                res_c.status = pix_ok ? mpfgd_pkg::STAT_DONE : mpfgd_pkg::STAT_CLIP;
            end
            mpfgd_pkg::FUNC_GLYPH:
            begin
                if (reject)
                begin
                    res_c.status = mpfgd_pkg::STAT_REJECT;
                end
                else
                begin
                    kind_c          = mpfgd_pkg::KIND_DRAW;
                    ncol_c          = draw_row ? font_w_reg : 5'd0;
                    x0_c            = cursor_x_reg;
                    y_c             = glyph_y;
                    pattern_c       = item_reg.glyph_bits;
                    res_c.char_done = last_row;
                end
            end
            mpfgd_pkg::FUNC_CURSOR:
            begin
                kind_c = mpfgd_pkg::KIND_NONE;
            end
            mpfgd_pkg::FUNC_READ:
            begin
                if (read_ok)
                    kind_c = mpfgd_pkg::KIND_READ;
                else
                    res_c.status = mpfgd_pkg::STAT_CLIP;
            end
            default:
            begin
                kind_c = mpfgd_pkg::KIND_NONE;
            end
        endcase
    end

    assign row_base_c  = ADDR_W'(32'(y_c[8:3]) * SCREEN_WIDTH);
    assign read_addr_c = ADDR_W'(32'(item_reg.pixel_y[7:3]) * SCREEN_WIDTH
                                 + 32'(item_reg.pixel_x));

    // column issue: read column col now, write it back next cycle
    assign col_x     = {2'b00, x0_reg} + {5'd0, col_reg};
    assign col_ok    = (col_x < WIDTH_L);
    assign col_bit   = col_reg[4] ? 1'b0 : pattern_reg[4'd15 - col_reg[3:0]];
    assign col_white = (col_bit ? color_reg : !color_reg) ^ inverted_reg;

    assign rd_en   = (cmd.decode && (kind_c == mpfgd_pkg::KIND_READ))
                  || (cmd.draw_step && col_ok);
    assign rd_addr = cmd.decode ? read_addr_c : (row_base_reg + ADDR_W'(col_x));

    assign mem_we    = cmd.sweep || wr_pend_reg;
    assign mem_waddr = cmd.sweep ? sweep_cnt_reg : wr_addr_reg;
    assign mem_wdata = cmd.sweep ? fill_byte_reg
                     : (wr_white_reg ? (rd_data_reg | mask_reg) : (rd_data_reg & ~mask_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_store_reg[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= frame_store_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverted_reg <= 1'b0;
            font_w_reg   <= mpfgd_pkg::RST_FONT_WIDTH;
            font_h_reg   <= mpfgd_pkg::RST_FONT_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mpfgd_pkg::CFG_INVERTED:    inverted_reg <= cfg_data[0];
                mpfgd_pkg::CFG_FONT_WIDTH:  font_w_reg   <= cfg_data[4:0];
                mpfgd_pkg::CFG_FONT_HEIGHT: font_h_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= 8'd0;
            cursor_y_reg  <= 8'd0;
            row_idx_reg   <= 5'd0;
            col_reg       <= 5'd0;
            wr_pend_reg   <= 1'b0;
            sweep_cnt_reg <= '0;
            fill_byte_reg <= mpfgd_pkg::BYTE_ZEROS;
        end
        else
        begin
            wr_pend_reg <= cmd.draw_step && col_ok;
            if (cmd.sweep)
                sweep_cnt_reg <= (sweep_cnt_reg == LAST_ADDR) ? '0
                                                              : sweep_cnt_reg + ADDR_W'(1);
            if (cmd.draw_step)
                col_reg <= col_reg + 5'd1;
            if (cmd.decode)
            begin
                col_reg <= 5'd0;
                if (item_reg.func == mpfgd_pkg::FUNC_FILL)
                    fill_byte_reg <= item_reg.color ? mpfgd_pkg::BYTE_ONES
                                                    : mpfgd_pkg::BYTE_ZEROS;
                if (item_reg.func == mpfgd_pkg::FUNC_CURSOR)
                begin
                    cursor_x_reg <= item_reg.pixel_x;
                    cursor_y_reg <= item_reg.pixel_y;
                    row_idx_reg  <= 5'd0;
                end
                else if ((item_reg.func == mpfgd_pkg::FUNC_GLYPH) && !reject)
                begin
                    if (last_row)
                    begin
                        row_idx_reg  <= 5'd0;
                        cursor_x_reg <= cursor_x_reg + {3'd0, font_w_reg};
                    end
                    else
                    begin
                        row_idx_reg <= row_idx_reg + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= item;
        if (cmd.decode)
        begin
            ncol_reg     <= ncol_c;
            x0_reg       <= x0_c;
            pattern_reg  <= pattern_c;
            color_reg    <= item_reg.color;
            row_base_reg <= row_base_c;
            mask_reg     <= 8'd1 << y_c[2:0];
            res_reg      <= res_c;
        end
        if (cmd.draw_step)
        begin
            wr_addr_reg  <= row_base_reg + ADDR_W'(col_x);
            wr_white_reg <= col_white;
        end
        if (cmd.read_latch)
            res_reg.read_data <= rd_data_reg;
        if (cmd.out_load)
            out_reg <= res_reg;
    end

    assign status.kind       = kind_c;
    assign status.draw_empty = (ncol_c == 5'd0);
    assign status.draw_last  = (({1'b0, col_reg} + 6'd1) == {1'b0, ncol_reg});
    assign status.sweep_last = (sweep_cnt_reg == LAST_ADDR);
    assign result            = out_reg;

endmodule

FILE: rtl/mono_page_framebuffer_glyph_draw_top.sv
`timescale 1ns / 1ps
// Top level of the page-mode monochrome framebuffer with glyph drawing.
// Instantiates mpfgd_ctrl and mpfgd_datapath; types from mpfgd_pkg.
//
// Usage:
//   item channel (item_valid/item_stall/item) carries one operation per
//   transaction; result channel (result_valid/result_stall/result) returns
//   exactly one result per item, in order. The cfg_write/cfg_index/cfg_data
//   port writes inverted, font_width and font_height; the user is to write
//   them only while the block is idle, which the block itself does not enforce.
//   One item is in work at a time. A glyph row is drawn one column per cycle:
//   the store reads column j while writing back column j-1 on its second
//   port. A fill writes one byte per cycle across the whole store.
//   result_valid rises at the edge that ends the finish step.
//   Reset: a clearing pass zeroes the store, one byte per cycle, over all
//   SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes (1024 at the defaults);
//   item_stall stays high meanwhile. Config writes are taken at any time.
//   A stalled result sits in the output register; the block still takes the
//   next item and only waits at its finish step until the register frees up.
module mono_page_framebuffer_glyph_draw_top #(
    parameter int SCREEN_WIDTH  = mpfgd_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = mpfgd_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  mpfgd_pkg::item_t                  item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output mpfgd_pkg::result_t                result,
    input  logic                              cfg_write,
    input  logic [mpfgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mpfgd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mpfgd_pkg::dp_cmd_t    cmd;
    mpfgd_pkg::dp_status_t status;

    mpfgd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    mpfgd_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

`ifndef ASSERT_OFF
    // an accepted transaction is decoded in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> cmd.decode)
        else $error("accepted item not decoded next cycle");

    // output register is never overwritten while it holds a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(result_valid && result_stall))
        else $error("result overwritten while stalled");

    // a new result only shows up after a load from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.out_load))
        else $error("result valid without load");

    // store sweeps never overlap taking a new item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> item_stall)
        else $error("item accepted during store sweep");
`endif

endmodule

FILE: sim/tb_mono_page_framebuffer_glyph_draw_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for mono_page_framebuffer_glyph_draw_top: a directed table, then
// randomized phases under several font/invert settings, checked by a framebuffer predictor
// where no result is typed. Depends on mpfgd_pkg and the top level; no external files.
module tb_mono_page_framebuffer_glyph_draw_top;

    localparam int SCR_W          = mpfgd_pkg::DEF_SCREEN_WIDTH;
    localparam int SCR_H          = mpfgd_pkg::DEF_SCREEN_HEIGHT;
    localparam int STORE_BYTES    = SCR_W * ((SCR_H + 7) / 8);
    localparam int RANDOM_ITEMS   = 480;
    localparam int PHASE_ITEMS    = 45;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        mpfgd_pkg::item_t   it;
        bit                 typed;
        mpfgd_pkg::result_t want;
        logic [1:0]         idx;
        logic [5:0]         val;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              item_valid;
    logic                              item_stall;
    mpfgd_pkg::item_t                  item;
    logic                              result_valid;
    logic                              result_stall;
    mpfgd_pkg::result_t                result;
    logic                              cfg_write;
    logic [mpfgd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mpfgd_pkg::CFG_DATA_W-1:0]  cfg_data;

    // framebuffer predictor state
    logic [7:0] shadow_fb [STORE_BYTES];
    logic [7:0] cur_x;
    logic [7:0] cur_y;
    logic [4:0] glyph_row;
    logic       cfg_inv;
    logic [4:0] cfg_fw;
    logic [5:0] cfg_fh;

    mpfgd_pkg::result_t pending_results[$];

    bit pace_on;
    int rx_hold_reqs;
    int items_issued;
    int results_seen;
    int n_errors;
    int n_chars;
    int n_rejects;
    int n_clips;
    int n_reads;
    int n_settings;

    int ph_inv [8] = '{0, 1, 0, 1, 0, 1, 0, 0};
    int ph_fw  [8] = '{7, 16, 1, 31, 0, 8, 5, 16};
    int ph_fh  [8] = '{10, 32, 1, 40, 5, 0, 63, 8};

    mono_page_framebuffer_glyph_draw_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // returns 0 when the pixel is off screen and nothing was written
    function automatic bit plot_dot(int x, int y, logic white);
        int addr;
        if (x >= SCR_W || y >= SCR_H)
            return 1'b0;
        addr = x + (y / 8) * SCR_W;
        if (cfg_inv)
            white = ~white;
        if (white)
            shadow_fb[addr] = shadow_fb[addr] | (8'h01 << (y % 8));
        else
            shadow_fb[addr] = shadow_fb[addr] & ~(8'h01 << (y % 8));
        return 1'b1;
    endfunction

    function automatic mpfgd_pkg::result_t frame_model_step(mpfgd_pkg::item_t it);
        mpfgd_pkg::result_t r;
        int                 eff_h;
        int                 page;
        logic               ink;
        r = '0;
        case (it.func)
            mpfgd_pkg::FUNC_FILL:
            begin
                foreach (shadow_fb[a])
                    shadow_fb[a] = it.color ? mpfgd_pkg::BYTE_ONES : mpfgd_pkg::BYTE_ZEROS;
            end
            mpfgd_pkg::FUNC_PIXEL:
            begin
                if (!plot_dot(it.pixel_x, it.pixel_y, it.color))
                begin
                    r.status = mpfgd_pkg::STAT_CLIP;
                    n_clips++;
                end
            end
            mpfgd_pkg::FUNC_GLYPH:
            begin
                // space is checked only when a character starts
                if (glyph_row == 0 && (int'(cur_x) + int'(cfg_fw) >= SCR_W ||
                                       int'(cur_y) + int'(cfg_fh) >= SCR_H))
                begin
                    r.status = mpfgd_pkg::STAT_REJECT;
                    n_rejects++;
                end
                else
                begin
                    eff_h = (cfg_fh > mpfgd_pkg::MAX_GLYPH_ROWS) ?
                            int'(mpfgd_pkg::MAX_GLYPH_ROWS) : int'(cfg_fh);
                    if (eff_h > 0)
                    begin
                        for (int j = 0; j < int'(cfg_fw); j++)
                        begin
                            // columns past the 16 glyph bits draw the opposite color
                            ink = (j < 16) ? it.glyph_bits[15 - j] : 1'b0;
                            void'(plot_dot(int'(cur_x) + j, int'(cur_y) + int'(glyph_row),
                                           ink ? it.color : ~it.color));
                        end
                    end
                    if (int'(glyph_row) + 1 >= eff_h)
                    begin
                        glyph_row   = '0;
                        cur_x       = cur_x + 8'(cfg_fw);
                        r.char_done = 1'b1;
                        n_chars++;
                    end
                    else
                        glyph_row = glyph_row + 5'd1;
                end
            end
            mpfgd_pkg::FUNC_CURSOR:
            begin
                cur_x     = it.pixel_x;
                cur_y     = it.pixel_y;
                glyph_row = '0;
            end
            mpfgd_pkg::FUNC_READ:
            begin
                page = it.pixel_y / 8;
                if (int'(it.pixel_x) >= SCR_W || page >= (SCR_H + 7) / 8)
                begin
                    r.status = mpfgd_pkg::STAT_CLIP;
                    n_clips++;
                end
                else
                begin
                    r.read_data = shadow_fb[int'(it.pixel_x) + page * SCR_W];
                    n_reads++;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        n_errors++;
    endtask

    // Entered at a falling edge; returns at the falling edge after the transaction.
    task automatic issue_item(input mpfgd_pkg::item_t it, input bit typed,
                              input mpfgd_pkg::result_t want);
        int                 gap;
        mpfgd_pkg::result_t guess;
        gap = pace_on ? gap_len() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        guess = frame_model_step(it);
        pending_results.push_back(typed ? want : guess);
        items_issued++;
        @(negedge clk);
    endtask

    task automatic issue_fields(input logic [2:0] f, input logic [7:0] x, input logic [7:0] y,
                                input logic c, input logic [15:0] b);
        mpfgd_pkg::item_t it;
        it.func       = f;
        it.pixel_x    = x;
        it.pixel_y    = y;
        it.color      = c;
        it.glyph_bits = b;
        issue_item(it, 1'b0, '0);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mpfgd_pkg::CFG_INVERTED:    cfg_inv = val[0];
            mpfgd_pkg::CFG_FONT_WIDTH:  cfg_fw  = val[4:0];
            mpfgd_pkg::CFG_FONT_HEIGHT: cfg_fh  = val;
            default:                    ;
        endcase
        @(negedge clk);
    endtask

    function automatic stim_row_t item_row(logic [2:0] f, logic [7:0] x, logic [7:0] y,
                                           logic c, logic [15:0] b);
        stim_row_t row;
        row.kind          = ROW_ITEM;
        row.it.func       = f;
        row.it.pixel_x    = x;
        row.it.pixel_y    = y;
        row.it.color      = c;
        row.it.glyph_bits = b;
        row.typed         = 1'b0;
        row.want          = '0;
        row.idx           = '0;
        row.val           = '0;
        return row;
    endfunction

    function automatic stim_row_t checked_row(logic [2:0] f, logic [7:0] x, logic [7:0] y,
                                              logic c, logic [15:0] b, logic [1:0] st,
                                              logic [7:0] rd, logic dn);
        stim_row_t row;
        row                = item_row(f, x, y, c, b);
        row.typed          = 1'b1;
        row.want.status    = st;
        row.want.read_data = rd;
        row.want.char_done = dn;
        return row;
    endfunction

    function automatic stim_row_t reg_row(logic [1:0] idx, logic [5:0] val);
        stim_row_t row;
        row      = item_row(mpfgd_pkg::FUNC_FILL, '0, '0, 1'b0, '0);
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.val  = val;
        return row;
    endfunction

    // result side: random backpressure plus one long hold on request
    initial
    begin : rx_pacing
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != rx_hold_reqs)
            begin
                holds_served++;
                result_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                if (pace_on && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        mpfgd_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                log_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    log_mismatch($sformatf("result %0d status 0x%0h, expected 0x%0h",
                                           results_seen, result.status, want.status));
                if (result.read_data !== want.read_data)
                    log_mismatch($sformatf("result %0d read_data 0x%0h, expected 0x%0h",
                                           results_seen, result.read_data, want.read_data));
                if (result.char_done !== want.char_done)
                    log_mismatch($sformatf("result %0d char_done %0b, expected %0b",
                                           results_seen, result.char_done, want.char_done));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ERROR no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb_mono_page_framebuffer_glyph_draw_top failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t  plan[$];
        int         phase;
        int         phase_end;
        int         random_end;
        int         rows;
        int         rows_this;
        int         nchars;
        logic [2:0] f;
        logic [7:0] cx;
        logic [7:0] cy;
        logic       col;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        pace_on      = 1'b1;
        rx_hold_reqs = 0;
        foreach (shadow_fb[a])
            shadow_fb[a] = mpfgd_pkg::BYTE_ZEROS;
        cur_x     = '0;
        cur_y     = '0;
        glyph_row = '0;
        cfg_inv   = 1'b0;
        cfg_fw    = mpfgd_pkg::RST_FONT_WIDTH;
        cfg_fh    = mpfgd_pkg::RST_FONT_HEIGHT;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table; typed results only where obvious
        plan.push_back(checked_row(mpfgd_pkg::FUNC_READ, 8'd0, 8'd0, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_DONE, mpfgd_pkg::BYTE_ZEROS, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_READ, 8'd128, 8'd0, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_CLIP, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_READ, 8'd0, 8'd64, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_CLIP, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_READ, 8'd255, 8'd255, 1'b1, 16'hFFFF,
                                   mpfgd_pkg::STAT_CLIP, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_PIXEL, 8'd0, 8'd0, 1'b1, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_PIXEL, 8'd127, 8'd63, 1'b1, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_PIXEL, 8'd128, 8'd5, 1'b1, 16'h0,
                                   mpfgd_pkg::STAT_CLIP, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_PIXEL, 8'd5, 8'd64, 1'b1, 16'h0,
                                   mpfgd_pkg::STAT_CLIP, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_READ, 8'd0, 8'd0, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h01, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_READ, 8'd127, 8'd63, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h80, 1'b0));
        plan.push_back(checked_row(FUNC_SPARE_LO, 8'hFF, 8'hFF, 1'b1, 16'hFFFF,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(checked_row(FUNC_SPARE_HI, 8'hFF, 8'hFF, 1'b1, 16'hFFFF,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_CURSOR, 8'd255, 8'd255, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF,
                                   mpfgd_pkg::STAT_REJECT, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_FILL, 8'd0, 8'd0, 1'b1, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_READ, 8'd64, 8'd32, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_DONE, mpfgd_pkg::BYTE_ONES, 1'b0));
        plan.push_back(reg_row(mpfgd_pkg::CFG_INVERTED, 6'h3F));
        plan.push_back(item_row(mpfgd_pkg::FUNC_PIXEL, 8'd3, 8'd3, 1'b1, 16'h0));
        plan.push_back(item_row(mpfgd_pkg::FUNC_READ, 8'd3, 8'd0, 1'b0, 16'h0));
        plan.push_back(reg_row(mpfgd_pkg::CFG_FONT_WIDTH, 6'h30));
        plan.push_back(reg_row(mpfgd_pkg::CFG_FONT_HEIGHT, 6'd2));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_CURSOR, 8'd10, 8'd8, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(item_row(mpfgd_pkg::FUNC_GLYPH, 8'd0, 8'd0, 1'b1, 16'hA5C3));
        plan.push_back(item_row(mpfgd_pkg::FUNC_GLYPH, 8'd0, 8'd0, 1'b0, 16'h0000));
        plan.push_back(reg_row(mpfgd_pkg::CFG_FONT_HEIGHT, 6'd3));
        plan.push_back(item_row(mpfgd_pkg::FUNC_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF));
        // height shrinks mid-character: the next row finishes it
        plan.push_back(reg_row(mpfgd_pkg::CFG_FONT_HEIGHT, 6'd1));
        plan.push_back(item_row(mpfgd_pkg::FUNC_GLYPH, 8'd0, 8'd0, 1'b0, 16'h1234));
        plan.push_back(reg_row(mpfgd_pkg::CFG_FONT_WIDTH, 6'd0));
        plan.push_back(reg_row(mpfgd_pkg::CFG_FONT_HEIGHT, 6'd0));
        plan.push_back(reg_row(CFG_UNUSED, 6'h3F));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_CURSOR, 8'd0, 8'd0, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b1));
        plan.push_back(reg_row(mpfgd_pkg::CFG_FONT_HEIGHT, 6'd14));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_CURSOR, 8'd0, 8'd50, 1'b0, 16'h0,
                                   mpfgd_pkg::STAT_DONE, 8'h00, 1'b0));
        plan.push_back(checked_row(mpfgd_pkg::FUNC_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF,
                                   mpfgd_pkg::STAT_REJECT, 8'h00, 1'b0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                issue_item(plan[i].it, plan[i].typed, plan[i].want);
        end

        random_end = items_issued + RANDOM_ITEMS;
        phase      = 0;
        while (items_issued < random_end)
        begin
            drain_results();
            if (phase < 8)
            begin
                write_reg(mpfgd_pkg::CFG_INVERTED, 6'(ph_inv[phase]));
                write_reg(mpfgd_pkg::CFG_FONT_WIDTH, 6'(ph_fw[phase]));
                write_reg(mpfgd_pkg::CFG_FONT_HEIGHT, 6'(ph_fh[phase]));
            end
            else
            begin
                write_reg(mpfgd_pkg::CFG_INVERTED, 6'($urandom));
                write_reg(mpfgd_pkg::CFG_FONT_WIDTH, 6'($urandom_range(0, 31)));
                write_reg(mpfgd_pkg::CFG_FONT_HEIGHT, ($urandom_range(0, 7) == 0) ?
                          6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32)));
            end
            n_settings++;
            pace_on = (phase % 3 != 2);

            // long result hold while items keep coming: the block backs up its input
            if (phase == 2)
            begin
                rx_hold_reqs++;
                repeat (8)
                    issue_fields(mpfgd_pkg::FUNC_READ, 8'($urandom_range(0, SCR_W - 1)),
                                 8'($urandom_range(0, SCR_H - 1)), 1'b0, 16'($urandom));
            end

            phase_end = items_issued + PHASE_ITEMS;
            while (items_issued < phase_end)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        // text: cursor mostly placed to fit, characters, the last maybe partial
                        cx = 8'($urandom_range(0, SCR_W - 1 - int'(cfg_fw)));
                        cy = 8'($urandom_range(0, SCR_H - 1 - int'(cfg_fh)));
                        if ($urandom_range(0, 5) == 0)
                        begin
                            cx = 8'($urandom);
                            cy = 8'($urandom);
                        end
                        issue_fields(mpfgd_pkg::FUNC_CURSOR, cx, cy, 1'($urandom),
                                     16'($urandom));
                        rows = (cfg_fh > mpfgd_pkg::MAX_GLYPH_ROWS) ?
                               int'(mpfgd_pkg::MAX_GLYPH_ROWS) : int'(cfg_fh);
                        if (rows == 0)
                            rows = 1;
                        nchars = $urandom_range(1, 3);
                        for (int c = 0; c < nchars; c++)
                        begin
                            col       = 1'($urandom);
                            rows_this = rows;
                            if (c == nchars - 1 && $urandom_range(0, 7) == 0)
                                rows_this = $urandom_range(1, rows);
                            repeat (rows_this)
                                issue_fields(mpfgd_pkg::FUNC_GLYPH, 8'($urandom),
                                             8'($urandom), col, 16'($urandom));
                        end
                        repeat ($urandom_range(1, 3))
                            issue_fields(mpfgd_pkg::FUNC_READ,
                                         cx + 8'($urandom_range(0, int'(cfg_fw) * nchars)),
                                         cy + 8'($urandom_range(0, rows - 1)),
                                         1'($urandom), 16'($urandom));
                    end
                    5, 6:
                    begin
                        cx = 8'($urandom_range(0, SCR_W + 7));
                        cy = 8'($urandom_range(0, SCR_H + 3));
                        issue_fields(mpfgd_pkg::FUNC_PIXEL, cx, cy, 1'($urandom),
                                     16'($urandom));
                        issue_fields(mpfgd_pkg::FUNC_READ, cx, cy, 1'($urandom),
                                     16'($urandom));
                    end
                    7, 8:
                    begin
                        f = 3'($urandom_range(0, 7));
                        if (f == mpfgd_pkg::FUNC_FILL && $urandom_range(0, 3) != 0)
                            f = mpfgd_pkg::FUNC_READ;
                        issue_fields(f, 8'($urandom), 8'($urandom), 1'($urandom),
                                     16'($urandom));
                    end
                    default:
                        issue_fields(mpfgd_pkg::FUNC_READ, 8'($urandom_range(0, SCR_W - 1)),
                                     8'($urandom_range(0, SCR_H - 1)), 1'($urandom),
                                     16'($urandom));
                endcase
            end
            phase++;
        end

        drain_results();
        $display("Run covered %0d transactions under %0d register settings, all five operations",
                 items_issued, n_settings);
        $display("plus unused codes: %0d characters done, %0d rejected, %0d clipped, %0d reads.",
                 n_chars, n_rejects, n_clips, n_reads);
        if (n_errors == 0)
            $display("tb_mono_page_framebuffer_glyph_draw_top passed");
        else
            $display("tb_mono_page_framebuffer_glyph_draw_top failed");
        $finish;
    end

endmodule
